/* rtl/lrts_pkg.sv */
// shared types and constants of the least-run task scheduler
`default_nettype none
package lrts_pkg;

    localparam int MAX_TASKS  = 16;
    localparam int COUNT_BITS = 16;
    localparam int ID_W       = $clog2(MAX_TASKS);
    localparam int HI_W       = $clog2(MAX_TASKS + 1);

    typedef logic [ID_W-1:0]       t_id;
    typedef logic [COUNT_BITS-1:0] t_cnt;
    typedef logic [HI_W-1:0]       t_hi;

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_START   = 2'd1;
    localparam logic [1:0] OP_DESTROY = 2'd2;
    localparam logic [1:0] OP_SWITCH  = 2'd3;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_CREATED = 2'd1,
        ST_READY   = 2'd2
    } t_slot;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_CREATE,
        CMD_START,
        CMD_DESTROY,
        CMD_INC
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op op;
        t_id     id;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic found;
        t_id  id;
        t_cnt cnt;
    } t_wave;

endpackage
`default_nettype wire

/* rtl/lrts_cell.sv */
// one task slot: state, run count and one stage of the scan chain
`default_nettype none
module lrts_cell
    import lrts_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_id   i_index,
    input  wire t_cmd  i_cmd,
    input  wire t_wave i_wave,
    output t_wave      o_wave,
    output t_slot      o_state
);

    t_slot r_state;
    t_cnt  r_cnt;
    t_wave r_wave;
    logic  hit;
    logic  take;

    assign hit  = (i_cmd.id == i_index);
    assign take = (r_state == ST_READY) && (!i_wave.found || (r_cnt < i_wave.cnt));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else if (hit) begin
            case (i_cmd.op)
                CMD_CREATE:  r_state <= ST_CREATED;
                CMD_START:   r_state <= ST_READY;
                CMD_DESTROY: r_state <= ST_EMPTY;
                default:     r_state <= r_state;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (hit) begin
            case (i_cmd.op)
                CMD_CREATE: r_cnt <= t_cnt'(1);
                CMD_INC: begin
                    if (r_cnt != '1) begin
                        r_cnt <= r_cnt + t_cnt'(1);
                    end
                end
                default:    r_cnt <= r_cnt;
            endcase
        end
    end

    // token moves one cell per cycle carrying the best candidate so far
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave.valid <= 1'b0;
        end else begin
            r_wave.valid <= i_wave.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_wave.found <= 1'b1;
            r_wave.id    <= i_index;
            r_wave.cnt   <= r_cnt;
        end else begin
            r_wave.found <= i_wave.found;
            r_wave.id    <= i_wave.id;
            r_wave.cnt   <= i_wave.cnt;
        end
    end

    assign o_wave  = r_wave;
    assign o_state = r_state;

endmodule
`default_nettype wire

/* rtl/least_run_task_scheduler_core.sv */
// top level of the least-run task scheduler: request control and the chain of slot cells
//
// Create, start and destroy are done in the cycle the request is taken and the result
// is registered. A switch sends a token down the row of MAX_TASKS slot cells, one cell
// per cycle; the winner is latched into r_best when the token leaves the last cell, and
// the reply is registered from r_best in S_FINISH once the output register is free. One
// request is in work at a time. The next one is taken only when the output register is
// empty or its result leaves in the same cycle, so a stalled result holds off the input.
`default_nettype none
module least_run_task_scheduler_core
    import lrts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // target_id[3:0], zero fill
    input  wire logic [1:0]  i_s_tuser,   // op[1:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // ok[0], result_id[4:1], running_id[8:5], zero fill
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_fsm;

    t_fsm  r_fsm, n_fsm;
    logic  r_out_valid, n_out_valid;
    logic  r_out_ok, n_out_ok;
    t_id   r_out_rid, n_out_rid;
    t_id   r_running, n_running;
    t_hi   r_highest, n_highest;
    t_wave r_best, n_best;

    t_cmd  cmd;
    t_wave wave_head;
    t_wave wave [MAX_TASKS];
    t_slot slot [MAX_TASKS];

    logic  accept;
    logic  out_free;
    logic [1:0] op;
    t_id   tid;
    t_hi   next_hi;
    t_wave tail;

    assign op       = i_s_tuser;
    assign tid      = i_s_tdata[ID_W-1:0];
    assign out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_fsm == S_IDLE) && out_free;
    assign accept   = i_s_tvalid && o_s_tready;
    assign tail     = wave[MAX_TASKS-1];
    assign next_hi  = (r_highest < t_hi'(MAX_TASKS)) ? r_highest + t_hi'(1) : t_hi'(MAX_TASKS);

    always_comb begin
        wave_head       = '0;
        wave_head.valid = accept && (op == OP_SWITCH);
    end

    genvar g;
    generate
        for (g = 0; g < MAX_TASKS; g++) begin : g_cell
            t_wave w_in;
            if (g == 0) begin : g_head
                assign w_in = wave_head;
            end else begin : g_link
                assign w_in = wave[g-1];
            end
            lrts_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (t_id'(g)),
                .i_cmd   (cmd),
                .i_wave  (w_in),
                .o_wave  (wave[g]),
                .o_state (slot[g])
            );
        end
    endgenerate

    always_comb begin
        n_fsm       = r_fsm;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_ok    = r_out_ok;
        n_out_rid   = r_out_rid;
        n_running   = r_running;
        n_highest   = r_highest;
        n_best      = r_best;
        cmd.op      = CMD_NONE;
        cmd.id      = tid;
        case (r_fsm)
            S_IDLE: begin
                if (accept) begin
                    n_out_ok  = 1'b0;
                    n_out_rid = '0;
                    case (op)
                        OP_CREATE: begin
                            n_highest   = next_hi;
                            n_out_valid = 1'b1;
                            if (next_hi < t_hi'(MAX_TASKS)) begin
                                cmd.op    = CMD_CREATE;
                                cmd.id    = next_hi[ID_W-1:0];
                                n_out_ok  = 1'b1;
                                n_out_rid = next_hi[ID_W-1:0];
                            end
                        end
                        OP_START: begin
                            n_out_valid = 1'b1;
                            if (slot[tid] == ST_CREATED) begin
                                cmd.op   = CMD_START;
                                n_out_ok = 1'b1;
                            end
                        end
                        OP_DESTROY: begin
                            n_out_valid = 1'b1;
                            if (slot[tid] != ST_EMPTY) begin
                                cmd.op   = CMD_DESTROY;
                                n_out_ok = 1'b1;
                            end
                        end
                        default: begin
                            n_fsm = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (tail.valid) begin
                    n_best = tail;
                    n_fsm  = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_fsm       = S_IDLE;
                    if (r_best.found) begin
                        cmd.op    = CMD_INC;
                        cmd.id    = r_best.id;
                        n_running = r_best.id;
                        n_out_ok  = 1'b1;
                        n_out_rid = r_best.id;
                    end else begin
                        n_running = '0;
                        n_out_ok  = 1'b0;
                        n_out_rid = '0;
                    end
                end
            end
            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_out_valid <= 1'b0;
            r_running   <= '0;
            r_highest   <= '0;
        end else begin
            r_fsm       <= n_fsm;
            r_out_valid <= n_out_valid;
            r_running   <= n_running;
            r_highest   <= n_highest;
            r_out_ok    <= n_out_ok;
            r_out_rid   <= n_out_rid;
            r_best      <= n_best;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(16 - 1 - 2 * ID_W){1'b0}}, r_running, r_out_rid, r_out_ok};

    logic [MAX_TASKS-1:0] wave_valids;
    always_comb begin
        for (int k = 0; k < MAX_TASKS; k++) begin
            wave_valids[k] = wave[k].valid;
        end
    end

    // at most one scan token in the chain
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(wave_valids))
        else $error("more than one scan token in flight");

    // no request taken while a scan is running
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_SCAN) || (r_fsm == S_FINISH) |-> !o_s_tready)
        else $error("request taken during scan");

    // only a switch changes the running task
    a_run_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == S_IDLE) |=> (r_running == $past(r_running)))
        else $error("running task changed outside a switch");

    // a failed request reports id zero
    a_fail_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> (o_m_tdata[4:1] == 4'd0))
        else $error("failed request with nonzero id");

    // the id counter never passes the table size
    a_hi_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_highest <= t_hi'(MAX_TASKS))
        else $error("issued id counter overflow");

endmodule
`default_nettype wire

/* test/lrts_result_checker.sv */
// reply checker for the least-run task scheduler: tracks the task table and compares every reply
`default_nettype none
module lrts_result_checker
    import lrts_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // target_id[3:0], zero fill
    input  wire logic [1:0]  i_s_tuser,   // op[1:0]
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [15:0] i_m_tdata,   // ok[0], result_id[4:1], running_id[8:5], zero fill
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic ok;
        t_id  result_id;
        t_id  running_id;
    } t_sched_reply;

    t_slot        task_slot [MAX_TASKS];
    t_cnt         task_runs [MAX_TASKS];
    int unsigned  last_issued;
    t_id          cur_task;
    t_sched_reply pending_replies [$];

    function automatic t_sched_reply schedule_step(input logic [1:0] op, input t_id tid);
        t_sched_reply r;
        int unsigned  nxt;
        int unsigned  scan_end;
        int unsigned  i;
        t_id          best;
        t_cnt         best_cnt;
        logic         found;
        r = '0;
        case (op)
            OP_CREATE: begin
                nxt = (last_issued + 1 > MAX_TASKS) ? MAX_TASKS : last_issued + 1;
                last_issued = nxt;
                if (nxt < MAX_TASKS) begin
                    task_slot[nxt] = ST_CREATED;
                    task_runs[nxt] = t_cnt'(1);
                    r.ok = 1'b1;
                    r.result_id = t_id'(nxt);
                end
            end
            OP_START: begin
                if (task_slot[tid] == ST_CREATED) begin
                    task_slot[tid] = ST_READY;
                    r.ok = 1'b1;
                end
            end
            OP_DESTROY: begin
                if (task_slot[tid] != ST_EMPTY) begin
                    task_slot[tid] = ST_EMPTY;
                    r.ok = 1'b1;
                end
            end
            default: begin
                scan_end = (last_issued > MAX_TASKS - 1) ? MAX_TASKS - 1 : last_issued;
                found = 1'b0;
                best = '0;
                best_cnt = '0;
                for (i = 1; i <= scan_end; i++) begin
                    if (task_slot[i] == ST_READY && (!found || task_runs[i] < best_cnt)) begin
                        found = 1'b1;
                        best = t_id'(i);
                        best_cnt = task_runs[i];
                    end
                end
                if (found) begin
                    // count saturates instead of wrapping
                    if (task_runs[best] != '1) task_runs[best] = task_runs[best] + 1'b1;
                    cur_task = best;
                    r.ok = 1'b1;
                    r.result_id = best;
                end else begin
                    cur_task = '0;
                end
            end
        endcase
        r.running_id = cur_task;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_sched_reply want;
        t_sched_reply got;
        if (!i_rst_n) begin
            for (int s = 0; s < MAX_TASKS; s++) begin
                task_slot[s] = ST_EMPTY;
                task_runs[s] = '0;
            end
            last_issued = 0;
            cur_task = '0;
            pending_replies.delete();
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.ok = i_m_tdata[0];
                got.result_id = i_m_tdata[4:1];
                got.running_id = i_m_tdata[8:5];
                if (pending_replies.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: reply with no request outstanding: ok=%0d id=%0d run=%0d",
                                 $realtime, got.ok, got.result_id, got.running_id);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.ok !== want.ok || got.result_id !== want.result_id ||
                        got.running_id !== want.running_id) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display({"%0t: reply mismatch: expected ok=%0d id=%0d run=%0d, ",
                                      "got ok=%0d id=%0d run=%0d"}, $realtime,
                                     want.ok, want.result_id, want.running_id,
                                     got.ok, got.result_id, got.running_id);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                pending_replies.push_back(schedule_step(i_s_tuser, t_id'(i_s_tdata[3:0])));
        end
        o_pending = pending_replies.size();
    end

endmodule
`default_nettype wire

/* test/testbench.sv */
// stimulus and verdict for the least-run task scheduler core
`default_nettype none
module testbench;
    import lrts_pkg::*;

    localparam int PHASE_ITEMS = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;   // target_id[3:0], zero fill
    logic [1:0]  i_s_tuser = OP_CREATE;   // op[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;   // ok[0], result_id[4:1], running_id[8:5], zero fill

    int          fail_count;
    int          pending;
    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    logic        rx_hold_req = 1'b0;

    always #2 i_clk = ~i_clk;

    least_run_task_scheduler_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    lrts_result_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // receiver side, with random stalls and one long hold-off
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    task automatic send_request(input logic [1:0] op, input t_id tid);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= op;
        i_s_tdata <= {4'd0, tid};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    task automatic wait_drained;
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic send_random;
        int unsigned pick;
        logic [1:0]  op;
        pick = $urandom_range(999);
        // creates and destroys kept rare so the table stays populated
        if (pick < 15) op = OP_CREATE;
        else if (pick < 25) op = OP_DESTROY;
        else if (pick < 350) op = OP_START;
        else op = OP_SWITCH;
        send_request(op, t_id'($urandom_range(15)));
    endtask

    initial begin
        int unsigned ph;
        int unsigned k;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle table, bad ids and empty slots
        send_request(OP_SWITCH, 4'd0);
        send_request(OP_START, 4'd0);
        send_request(OP_DESTROY, 4'd0);
        send_request(OP_DESTROY, 4'd15);
        send_request(OP_START, 4'd15);
        send_request(OP_CREATE, 4'd15);
        send_request(OP_CREATE, 4'd0);
        send_request(OP_CREATE, 4'd7);
        // nothing ready yet
        send_request(OP_SWITCH, 4'd0);
        send_request(OP_START, 4'd1);
        send_request(OP_START, 4'd1);
        send_request(OP_START, 4'd2);
        // least run count wins, a tie goes to the lowest id
        send_request(OP_SWITCH, 4'd0);
        send_request(OP_SWITCH, 4'd0);
        send_request(OP_SWITCH, 4'd0);
        // destroying the running task leaves it current until the next switch
        send_request(OP_DESTROY, 4'd1);
        send_request(OP_DESTROY, 4'd1);
        send_request(OP_START, 4'd3);
        send_request(OP_SWITCH, 4'd0);
        send_request(OP_DESTROY, 4'd3);
        send_request(OP_SWITCH, 4'd0);
        send_request(OP_DESTROY, 4'd3);
        send_request(OP_SWITCH, 4'd0);
        wait_drained();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 57; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 57; end
                default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
            endcase
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 0 && k == 100) rx_hold_req = 1'b1;
                if (k == 250) wait_drained();
                send_random();
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("least_run_task_scheduler_core test passed");
        else
            $display("least_run_task_scheduler_core test failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("least_run_task_scheduler_core test failed");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/lrts_pkg.sv
rtl/lrts_cell.sv
rtl/least_run_task_scheduler_core.sv
test/lrts_result_checker.sv
test/testbench.sv
